FILE: design/bffa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam int WORD_BITS  = 32;
	localparam int CHUNK_BITS = 8;

	typedef struct packed {
		logic        op;
		logic [10:0] size_bytes;
		logic [9:0]  address;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [9:0]  block_address;
		logic [10:0] free_bytes;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SET,
		ST_FREE,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: design/bffa_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_req_if
// Request channel: valid/ready handshake carrying one allocate or free beat.
// ----------------------------------------------------------------------------
interface bffa_req_if;
	logic            valid;
	logic            ready;
	bffa_pkg::req_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/bffa_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_rsp_if
// Response channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface bffa_rsp_if;
	logic            valid;
	logic            ready;
	bffa_pkg::rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/bitmap_first_fit_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_core
// Granule bitmap allocator: first-fit allocate with guard granule, run free.
// ----------------------------------------------------------------------------
// Allocate: accept the request, scan the bitmap in 8-granule slices, write back
//   each bitmap word the run touches, then post the result beat.
// Free: accept the request, walk the run in 8-granule slices, post the result.
// One request at a time; the bitmap RAM's single read port sets the pace.
// After reset the bitmap is cleared word by word before the first request
// is taken.
module bitmap_first_fit_allocator_core #(
	parameter int WORDS = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bffa_req_if.sink    req,
	bffa_rsp_if.source  rsp
);
	import bffa_pkg::*;

	localparam int WA       = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int GW       = WA + 5;
	localparam int GRANULES = WORDS * WORD_BITS;
	localparam int GLW      = $clog2(GRANULES + 1);
	localparam int CMPW     = (GLW + 2 > 11) ? GLW + 2 : 11;
	localparam logic [WA-1:0] LAST_W = WA'(WORDS - 1);

	state_t state_q, state_d;

	logic [WA-1:0]  clr_idx_q;
	logic [GLW-1:0] gl_q;
	logic           rsp_valid_q;
	rsp_t           rsp_data_q;

	logic [9:0]     need_q;
	logic [WA-1:0]  w_q;
	logic [1:0]     c_q;
	logic [2:0]     skip_q;
	logic           in_run_q;
	logic [GW-1:0]  s_q;
	logic [GW-1:0]  e_q;
	logic [9:0]     cnt_q;
	logic [31:0]    clr_q;
	logic           freed_q;
	logic           res_ok_q;
	logic [9:0]     res_addr_q;

	logic           ram_we;
	logic [WA-1:0]  ram_waddr;
	logic [31:0]    ram_wdata;
	logic           ram_re;
	logic [WA-1:0]  ram_raddr;
	logic [31:0]    rd_data;

	bffa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// request decode
	logic           req_fire;
	logic [9:0]     need_in;
	logic           alloc_reject;
	logic [WA-1:0]  free_w;
	logic           free_in_pool;

	assign req.ready    = (state_q == ST_IDLE);
	assign req_fire     = req.valid && req.ready;
	assign need_in      = {1'b0, req.data.size_bytes[10:2]} + 10'(|req.data.size_bytes[1:0]);
	assign alloc_reject = (req.data.size_bytes == 11'd0) ||
	                      (CMPW'(req.data.size_bytes) > CMPW'({gl_q, 2'b00}));
	assign free_w       = WA'(req.data.address[9:7]);
	assign free_in_pool = 11'(req.data.address[9:7]) < 11'(WORDS);

	// current 8-granule slice; bit 7 is the lowest granule of the slice
	logic [7:0] chunk_bits;
	assign chunk_bits = rd_data[{~c_q, 3'b000} +: CHUNK_BITS];

	// allocate scan over one slice
	logic          run_v;
	logic [GW-1:0] s_v;
	logic [9:0]    cnt_v;
	logic          fit_v;
	logic [GW-1:0] g_v;
	logic          at_end;
	logic          alloc_found;
	logic [GW-1:0] e_v;

	always_comb begin
		run_v = in_run_q;
		s_v   = s_q;
		cnt_v = cnt_q;
		fit_v = 1'b0;
		g_v   = '0;
		for (int i = 0; i < CHUNK_BITS; i++) begin
			if (!fit_v) begin
				g_v = {w_q, c_q, 3'(i)};
				if (chunk_bits[7-i]) begin
					run_v = 1'b0;
				end else if (!run_v) begin
					// run opens: skip its first granule as guard unless at pool start
					run_v = 1'b1;
					if (g_v == '0) begin
						s_v   = '0;
						cnt_v = 10'd1;
					end else begin
						s_v   = g_v + GW'(1);
						cnt_v = 10'd0;
					end
				end else begin
					cnt_v = cnt_v + 10'd1;
					if (cnt_v == need_q + 10'd1) begin
						fit_v = 1'b1;
					end
				end
			end
		end
	end

	assign at_end      = (w_q == LAST_W) && (c_q == 2'd3);
	assign alloc_found = fit_v || (at_end && run_v && (cnt_v >= need_q));
	assign e_v         = s_v + GW'(need_q - 10'd1);

	// set mask for the word being written back
	logic [4:0]  lo_off;
	logic [4:0]  hi_off;
	logic [31:0] set_mask;

	assign lo_off   = (w_q == s_q[GW-1:5]) ? s_q[4:0] : 5'd0;
	assign hi_off   = (w_q == e_q[GW-1:5]) ? e_q[4:0] : 5'd31;
	assign set_mask = ({32{1'b1}} >> lo_off) & ~(({32{1'b1}} >> hi_off) >> 1);

	// free walk over one slice
	logic [7:0]  msk_v;
	logic        stop_v;
	logic [3:0]  n_v;
	logic [31:0] clr_word;

	always_comb begin
		msk_v  = '0;
		stop_v = 1'b0;
		n_v    = '0;
		for (int i = 0; i < CHUNK_BITS; i++) begin
			if ((3'(i) >= skip_q) && !stop_v) begin
				if (chunk_bits[7-i]) begin
					msk_v[7-i] = 1'b1;
				end else begin
					stop_v = 1'b1;
				end
			end
		end
		for (int i = 0; i < CHUNK_BITS; i++) begin
			n_v = n_v + 4'(msk_v[i]);
		end
	end

	assign clr_word = clr_q | (32'(msk_v) << {~c_q, 3'b000});

	// state machine and RAM control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = w_q;
		ram_wdata = rd_data;
		ram_re    = 1'b0;
		ram_raddr = w_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '0;
				if (clr_idx_q == LAST_W) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_fire) begin
					if (req.data.op == OP_ALLOC) begin
						if (alloc_reject) begin
							state_d = ST_DONE;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = '0;
							state_d   = ST_SCAN;
						end
					end else begin
						if (free_in_pool) begin
							ram_re    = 1'b1;
							ram_raddr = free_w;
							state_d   = ST_FREE;
						end else begin
							state_d = ST_DONE;
						end
					end
				end
			end
			ST_SCAN: begin
				if (alloc_found) begin
					ram_re    = 1'b1;
					ram_raddr = s_v[GW-1:5];
					state_d   = ST_SET;
				end else if (c_q == 2'd3) begin
					if (at_end) begin
						state_d = ST_DONE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = w_q + WA'(1);
					end
				end
			end
			ST_SET: begin
				ram_we    = 1'b1;
				ram_wdata = rd_data | set_mask;
				if (w_q == e_q[GW-1:5]) begin
					state_d = ST_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = w_q + WA'(1);
				end
			end
			ST_FREE: begin
				if (stop_v || (c_q == 2'd3)) begin
					ram_we    = 1'b1;
					ram_wdata = rd_data & ~clr_word;
				end
				if (stop_v || ((c_q == 2'd3) && (w_q == LAST_W))) begin
					state_d = ST_DONE;
				end else if (c_q == 2'd3) begin
					ram_re    = 1'b1;
					ram_raddr = w_q + WA'(1);
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			gl_q        <= GLW'(GRANULES);
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + WA'(1);
			end
			if ((state_q == ST_SCAN) && alloc_found) begin
				gl_q <= gl_q - GLW'(need_q);
			end else if (state_q == ST_FREE) begin
				gl_q <= gl_q + GLW'(n_v);
			end
			if ((state_q == ST_DONE) && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					need_q     <= need_in;
					w_q        <= (req.data.op == OP_ALLOC) ? '0 : free_w;
					c_q        <= (req.data.op == OP_ALLOC) ? 2'd0 : req.data.address[6:5];
					skip_q     <= (req.data.op == OP_ALLOC) ? 3'd0 : req.data.address[4:2];
					in_run_q   <= 1'b0;
					s_q        <= '0;
					cnt_q      <= '0;
					clr_q      <= '0;
					freed_q    <= 1'b0;
					res_ok_q   <= 1'b0;
					res_addr_q <= '0;
				end
			end
			ST_SCAN: begin
				in_run_q <= run_v;
				s_q      <= s_v;
				cnt_q    <= cnt_v;
				if (alloc_found) begin
					e_q        <= e_v;
					w_q        <= s_v[GW-1:5];
					res_ok_q   <= 1'b1;
					res_addr_q <= 10'({s_v, 2'b00});
				end else if (c_q == 2'd3) begin
					w_q <= w_q + WA'(1);
					c_q <= 2'd0;
				end else begin
					c_q <= c_q + 2'd1;
				end
			end
			ST_SET: begin
				w_q <= w_q + WA'(1);
			end
			ST_FREE: begin
				freed_q  <= freed_q | (|msk_v);
				res_ok_q <= freed_q | (|msk_v);
				skip_q   <= 3'd0;
				if (c_q == 2'd3) begin
					// advance to the next word with a fresh clear mask
					c_q   <= 2'd0;
					w_q   <= w_q + WA'(1);
					clr_q <= '0;
				end else begin
					c_q   <= c_q + 2'd1;
					clr_q <= clr_word;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_data_q.ok            <= res_ok_q;
					rsp_data_q.block_address <= res_addr_q;
					rsp_data_q.free_bytes    <= 11'({gl_q, 2'b00});
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule
`default_nettype wire

FILE: design/bffa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire
